### hdl/pfcp_pkg.sv
`default_nettype none

package pfcp_pkg;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 24;
    localparam int LIMIT_W = 8;
    localparam int EVENT_W = 3;

    localparam logic [BYTE_W-1:0] CH_START = 8'h57;
    localparam logic [BYTE_W-1:0] CH_END   = 8'h58;
    localparam logic [BYTE_W-1:0] CH_TEMP  = 8'h54;
    localparam logic [BYTE_W-1:0] CH_LEARN = 8'h4C;
    localparam logic [BYTE_W-1:0] CH_ID    = 8'h46;
    localparam logic [BYTE_W-1:0] CH_MODE  = 8'h4D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 24'd9999999;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE    = 3'd0,
        EV_LIMIT   = 3'd1,
        EV_LEARN   = 3'd2,
        EV_ID      = 3'd3,
        EV_MODE    = 3'd4,
        EV_UNKNOWN = 3'd5
    } event_t;

endpackage

`default_nettype wire

### hdl/pfcp_dec_acc.sv
`default_nettype none

module pfcp_dec_acc (
    input  wire logic [pfcp_pkg::VALUE_W-1:0] acc_i,
    input  wire logic [pfcp_pkg::BYTE_W-1:0]  byte_i,
    output logic                               is_digit_o,
    output logic [pfcp_pkg::VALUE_W-1:0]      acc_o
);
    import pfcp_pkg::*;

    localparam int PROD_W = VALUE_W + 4;

    logic [PROD_W-1:0] times_ten;
    logic [PROD_W-1:0] sum;
    logic [BYTE_W-1:0] digit;

    always_comb begin
        is_digit_o = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
        digit      = byte_i - CH_ZERO;
        times_ten  = {1'b0, acc_i, 3'b000} + {3'b000, acc_i, 1'b0};
        sum        = times_ten + PROD_W'(digit[3:0]);
        if (sum > PROD_W'(VALUE_MAX)) begin
            acc_o = VALUE_MAX;
        end else begin
            acc_o = sum[VALUE_W-1:0];
        end
    end

endmodule

`default_nettype wire

### hdl/panel_frame_command_parser_core.sv
`default_nettype none
// Command frame parser for a serial control panel.
// The input channel (s_valid, s_ready, s_rx_byte) takes one received byte per item.
// A frame is 'W', a command letter, a payload and a closing 'X'. The payload's
// leading decimal digits form a value that saturates at 9999999.
// The result channel (m_valid, m_ready, m_*) gives exactly one item per input byte:
// the event code, the value of a frame closed by that byte, and the current
// temperature limit and mode settings after that byte.
// An accepted byte is held in an input register; when the result register can
// advance, it goes through the parser into the result register, which presents
// its result. One byte per cycle is sustained while the receiver takes results
// every cycle.
// When the receiver stalls, the result register holds its item and the input
// register fills; s_ready drops only once both are full.
// Reset (aresetn low at a clock edge) empties both registers, closes any open
// frame and clears the temperature limit and the mode.

module panel_frame_command_parser_core #(
    parameter int MAX_FRAME = 10
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [pfcp_pkg::BYTE_W-1:0]       s_rx_byte,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [pfcp_pkg::EVENT_W-1:0]           m_event_res,
    output logic [pfcp_pkg::VALUE_W-1:0]           m_value,
    output logic [pfcp_pkg::LIMIT_W-1:0]           m_temp_limit,
    output logic [pfcp_pkg::VALUE_W-1:0]           m_mode_value
);
    import pfcp_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME);
    localparam logic [CNT_W:0] FRAME_LIMIT = (CNT_W + 1)'(MAX_FRAME);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                out_valid_reg;
    event_t              out_event_reg;
    logic [VALUE_W-1:0]  out_value_reg;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [BYTE_W-1:0]   cmd_reg, cmd_next;
    logic [VALUE_W-1:0]  acc_reg, acc_next;
    logic                ended_reg, ended_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic [VALUE_W-1:0]  mode_reg, mode_next;
    event_t              event_next;
    logic [VALUE_W-1:0]  value_next;

    logic                advance;
    logic                fire;
    logic                is_digit;
    logic [VALUE_W-1:0]  acc_step;
    logic [BYTE_W-1:0]   cmd_sel;
    logic [CNT_W:0]      count_inc;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    pfcp_dec_acc u_dec_acc (
        .acc_i      (acc_reg),
        .byte_i     (in_byte_reg),
        .is_digit_o (is_digit),
        .acc_o      (acc_step)
    );

    always_comb begin
        count_next = count_reg;
        cmd_next   = cmd_reg;
        acc_next   = acc_reg;
        ended_next = ended_reg;
        limit_next = limit_reg;
        mode_next  = mode_reg;
        event_next = EV_NONE;
        value_next = '0;
        cmd_sel    = (count_reg == CNT_ONE) ? CH_END : cmd_reg;
        count_inc  = {1'b0, count_reg} + (CNT_W + 1)'(1);

        if (count_reg == '0) begin
            if (in_byte_reg == CH_START) begin
                count_next = CNT_ONE;
            end
        end else if (in_byte_reg == CH_END) begin
            value_next = acc_reg;
            case (cmd_sel)
                CH_TEMP: begin
                    limit_next = acc_reg[LIMIT_W-1:0];
                    event_next = EV_LIMIT;
                end
                CH_LEARN: event_next = EV_LEARN;
                CH_ID:    event_next = EV_ID;
                CH_MODE: begin
                    mode_next  = acc_reg;
                    event_next = EV_MODE;
                end
                default:  event_next = EV_UNKNOWN;
            endcase
            count_next = '0;
            cmd_next   = '0;
            acc_next   = '0;
            ended_next = 1'b0;
        end else begin
            if (count_reg == CNT_ONE) begin
                cmd_next = in_byte_reg;
            end else if (!ended_reg) begin
                if (is_digit) begin
                    acc_next = acc_step;
                end else begin
                    ended_next = 1'b1;
                end
            end
            if (count_inc >= FRAME_LIMIT) begin
                count_next = '0;
                cmd_next   = '0;
                acc_next   = '0;
                ended_next = 1'b0;
            end else begin
                count_next = count_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            cmd_reg       <= '0;
            acc_reg       <= '0;
            ended_reg     <= 1'b0;
            limit_reg     <= '0;
            mode_reg      <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                count_reg <= count_next;
                cmd_reg   <= cmd_next;
                acc_reg   <= acc_next;
                ended_reg <= ended_next;
                limit_reg <= limit_next;
                mode_reg  <= mode_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
        if (fire) begin
            out_event_reg <= event_next;
            out_value_reg <= value_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_event_res  = out_event_reg;
    assign m_value      = out_value_reg;
    assign m_temp_limit = limit_reg;
    assign m_mode_value = mode_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, count_reg} < FRAME_LIMIT)
        else $error("Frame byte count reached the frame limit.");

    a_acc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg <= VALUE_MAX)
        else $error("Digit accumulator exceeds the saturation value.");

    a_close_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && event_next != EV_NONE) |=> (count_reg == '0 && acc_reg == '0))
        else $error("Frame state not cleared after a frame closed.");

    a_value_only_on_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_event_res != EV_NONE || m_value == '0))
        else $error("Nonzero value reported without an event.");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_mode_value)
            && $stable(m_temp_limit)))
        else $error("Settings changed while a result was stalled.");

endmodule

`default_nettype wire
